>>> design/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types, opcode and status codes for the RV32I execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvex_pkg;

  localparam int unsigned XLEN = 32;

  // instruction kinds
  localparam logic [5:0] OP_ADD   = 6'd0;
  localparam logic [5:0] OP_SUB   = 6'd1;
  localparam logic [5:0] OP_AND   = 6'd2;
  localparam logic [5:0] OP_OR    = 6'd3;
  localparam logic [5:0] OP_XOR   = 6'd4;
  localparam logic [5:0] OP_SLL   = 6'd5;
  localparam logic [5:0] OP_SRL   = 6'd6;
  localparam logic [5:0] OP_SRA   = 6'd7;
  localparam logic [5:0] OP_SLT   = 6'd8;
  localparam logic [5:0] OP_SLTU  = 6'd9;
  localparam logic [5:0] OP_ADDI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd11;
  localparam logic [5:0] OP_ORI   = 6'd12;
  localparam logic [5:0] OP_XORI  = 6'd13;
  localparam logic [5:0] OP_SLLI  = 6'd14;
  localparam logic [5:0] OP_SRLI  = 6'd15;
  localparam logic [5:0] OP_SRAI  = 6'd16;
  localparam logic [5:0] OP_SLTI  = 6'd17;
  localparam logic [5:0] OP_SLTIU = 6'd18;
  localparam logic [5:0] OP_LW    = 6'd19;
  localparam logic [5:0] OP_LH    = 6'd20;
  localparam logic [5:0] OP_LB    = 6'd21;
  localparam logic [5:0] OP_LHU   = 6'd22;
  localparam logic [5:0] OP_LBU   = 6'd23;
  localparam logic [5:0] OP_SW    = 6'd24;
  localparam logic [5:0] OP_SH    = 6'd25;
  localparam logic [5:0] OP_SB    = 6'd26;
  localparam logic [5:0] OP_BEQ   = 6'd27;
  localparam logic [5:0] OP_BNE   = 6'd28;
  localparam logic [5:0] OP_BLT   = 6'd29;
  localparam logic [5:0] OP_BLTU  = 6'd30;
  localparam logic [5:0] OP_BGE   = 6'd31;
  localparam logic [5:0] OP_BGEU  = 6'd32;
  localparam logic [5:0] OP_JAL   = 6'd33;
  localparam logic [5:0] OP_JALR  = 6'd34;
  localparam logic [5:0] OP_LUI   = 6'd35;
  localparam logic [5:0] OP_AUIPC = 6'd36;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_IMM    = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_WINDOW = 3'd3;
  localparam logic [2:0] ST_HALT   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_START_PC = 2'd0;
  localparam logic [1:0] REG_WIN_LO   = 2'd1;
  localparam logic [1:0] REG_WIN_HI   = 2'd2;

  localparam logic [31:0] WIN_LO_RESET = 32'd2000000000;
  localparam logic [31:0] WIN_HI_RESET = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    LD_W,
    LD_H,
    LD_B,
    LD_HU,
    LD_BU
  } ld_kind_e;

  typedef struct packed {
    logic [5:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [20:0] immediate;
    logic [31:0]        target_address;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_wr;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        is_load;
    ld_kind_e    ld_kind;
    logic        mem_wr;
    logic [31:0] mem_addr;
    logic [31:0] mem_val;
    logic [2:0]  status;
  } exe_res_t;

  // sub-word extraction of a loaded word
  function automatic logic [31:0] load_ext(ld_kind_e kind, logic [31:0] w);
    logic [31:0] r;
    unique case (kind)
      LD_W:    r = w;
      LD_H:    r = {{16{w[15]}}, w[15:0]};
      LD_B:    r = {{24{w[7]}}, w[7:0]};
      LD_HU:   r = {16'h0000, w[15:0]};
      LD_BU:   r = {24'h000000, w[7:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/rvex_if.sv
// ----------------------------------------------------------------------------
// rvex_in_if / rvex_out_if
// Valid/ready channels carrying instructions in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvex_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         opcode;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [20:0] immediate;
  logic [31:0]        target_address;

  modport source (output valid, opcode, dest_reg, src1_reg, src2_reg, immediate,
                  target_address, input ready);
  modport sink (input valid, opcode, dest_reg, src1_reg, src2_reg, immediate,
                target_address, output ready);
endinterface

interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc_after;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_written;
  logic [31:0] mem_address;
  logic [31:0] mem_value;
  logic [2:0]  status;

  modport source (output valid, pc_after, reg_written, reg_index, reg_value,
                  mem_written, mem_address, mem_value, status, input ready);
  modport sink (input valid, pc_after, reg_written, reg_index, reg_value,
                mem_written, mem_address, mem_value, status, output ready);
endinterface

`default_nettype wire

>>> design/rvex_widx.sv
// ----------------------------------------------------------------------------
// rvex_widx
// Maps a byte address to a word index, address modulo the memory depth.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_widx #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic [31:0]                  addr_i,
  output logic [$clog2(MEM_WORDS)-1:0] idx_o
);
  localparam int unsigned IdxW = $clog2(MEM_WORDS);

  if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_pow2
    // power of two: plain mask
    assign idx_o = addr_i[IdxW-1:0];
  end else begin : g_mod
    localparam int unsigned SumW = IdxW + 2;
    logic [IdxW-1:0] part [4];
    logic [SumW-1:0] sum;
    logic [SumW-1:0] sum1;
    logic [SumW-1:0] sum2;

    // residue of each byte times its weight, from constant tables
    for (genvar k = 0; k < 4; k++) begin : g_byte
      localparam longint unsigned Pw = (64'd1 << (8 * k)) % MEM_WORDS;
      logic [IdxW-1:0] tab [256];
      for (genvar v = 0; v < 256; v++) begin : g_ent
        localparam longint unsigned Ent = (v * Pw) % MEM_WORDS;
        assign tab[v] = IdxW'(Ent);
      end
      assign part[k] = tab[addr_i[8*k +: 8]];
    end

    // sum stays below four depths: two conditional subtracts
    assign sum  = SumW'(part[0]) + SumW'(part[1]) + SumW'(part[2]) + SumW'(part[3]);
    assign sum1 = (sum >= SumW'(2 * MEM_WORDS)) ? sum - SumW'(2 * MEM_WORDS) : sum;
    assign sum2 = (sum1 >= SumW'(MEM_WORDS)) ? sum1 - SumW'(MEM_WORDS) : sum1;
    assign idx_o = sum2[IdxW-1:0];
  end

endmodule

`default_nettype wire

>>> design/rvex_regfile.sv
// ----------------------------------------------------------------------------
// rvex_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  rd_addr1_i,
  input  logic [4:0]  rd_addr2_i,
  output logic [31:0] rd_data1_o,
  output logic [31:0] rd_data2_o,
  input  logic        wr_en_i,
  input  logic [4:0]  wr_addr_i,
  input  logic [31:0] wr_data_i
);
  logic [31:0] mem [32];
  logic [31:0] valid_q;
  logic [31:0] rd_data1_q;
  logic [31:0] rd_data2_q;
  logic        wr_live;

  assign wr_live = wr_en_i && (wr_addr_i != 5'd0);

  // valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_live) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_live) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // reads with bypass of a same-edge write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (rd_addr1_i == 5'd0) begin
        rd_data1_q <= '0;
      end else if (wr_live && wr_addr_i == rd_addr1_i) begin
        rd_data1_q <= wr_data_i;
      end else begin
        rd_data1_q <= valid_q[rd_addr1_i] ? mem[rd_addr1_i] : '0;
      end
      if (rd_addr2_i == 5'd0) begin
        rd_data2_q <= '0;
      end else if (wr_live && wr_addr_i == rd_addr2_i) begin
        rd_data2_q <= wr_data_i;
      end else begin
        rd_data2_q <= valid_q[rd_addr2_i] ? mem[rd_addr2_i] : '0;
      end
    end
  end

  assign rd_data1_o = rd_data1_q;
  assign rd_data2_o = rd_data2_q;

endmodule

`default_nettype wire

>>> design/rvex_dmem.sv
// ----------------------------------------------------------------------------
// rvex_dmem
// Word data memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_dmem #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_idx_i,
  output logic [31:0]                  rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MEM_WORDS)-1:0] wr_idx_i,
  input  logic [31:0]                  wr_data_i,
  output logic                         busy_o
);
  localparam int unsigned IdxW = $clog2(MEM_WORDS);

  logic [31:0]     mem [MEM_WORDS];
  logic [31:0]     rd_data_q;
  logic            busy_q;
  logic [IdxW-1:0] clr_idx_q;

  // clearing sweep, one word a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      if (clr_idx_q == IdxW'(MEM_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

>>> design/rvex_exec.sv
// ----------------------------------------------------------------------------
// rvex_exec
// Decode, ALU, branch resolve, address generation and range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_exec (
  input  rvex_pkg::item_t    item_i,
  input  logic [31:0]        rs1_val_i,
  input  logic [31:0]        rs2_val_i,
  input  logic [31:0]        pc_i,
  input  logic               halted_i,
  input  logic [31:0]        win_lo_i,
  input  logic [31:0]        win_hi_i,
  output rvex_pkg::exe_res_t res_o
);
  import rvex_pkg::*;

  logic [31:0]        imm32;
  logic [31:0]        op2;
  logic [4:0]         shamt;
  logic [31:0]        alu_val;
  logic               imm12_ok;
  logic               shamt_ok;
  logic               imm20_ok;
  logic signed [34:0] auipc_sum;
  logic               auipc_in_win;
  logic               take;
  logic [31:0]        maddr;
  exe_res_t           r;

  // immediate forms and range checks
  assign imm32    = {{11{item_i.immediate[20]}}, item_i.immediate};
  assign imm12_ok = (&item_i.immediate[20:11]) || !(|item_i.immediate[20:11]);
  assign shamt_ok = !(|item_i.immediate[20:5]);
  assign imm20_ok = item_i.immediate[20] == item_i.immediate[19];
  assign op2      = (item_i.opcode <= OP_SLTU) ? rs2_val_i : imm32;
  assign shamt    = op2[4:0];
  assign maddr    = rs1_val_i + imm32;

  // exact pc + (imm << 12) against the window
  assign auipc_sum = $signed({3'b000, pc_i})
                   + $signed({{2{item_i.immediate[20]}}, item_i.immediate, 12'h000});
  assign auipc_in_win = !(auipc_sum < $signed({3'b000, win_lo_i}))
                     && !(auipc_sum > $signed({3'b000, win_hi_i}));

  // alu
  always_comb begin
    case (item_i.opcode) inside
      OP_ADD, OP_ADDI:   alu_val = rs1_val_i + op2;
      OP_SUB:            alu_val = rs1_val_i - op2;
      OP_AND, OP_ANDI:   alu_val = rs1_val_i & op2;
      OP_OR, OP_ORI:     alu_val = rs1_val_i | op2;
      OP_XOR, OP_XORI:   alu_val = rs1_val_i ^ op2;
      OP_SLL, OP_SLLI:   alu_val = rs1_val_i << shamt;
      OP_SRL, OP_SRLI:   alu_val = rs1_val_i >> shamt;
      OP_SRA, OP_SRAI:   alu_val = 32'($signed(rs1_val_i) >>> shamt);
      OP_SLT, OP_SLTI:   alu_val = {31'd0, $signed(rs1_val_i) < $signed(op2)};
      OP_SLTU, OP_SLTIU: alu_val = {31'd0, rs1_val_i < op2};
      default:           alu_val = '0;
    endcase
  end

  // branch condition
  always_comb begin
    case (item_i.opcode)
      OP_BEQ:  take = rs1_val_i == rs2_val_i;
      OP_BNE:  take = rs1_val_i != rs2_val_i;
      OP_BLT:  take = $signed(rs1_val_i) < $signed(rs2_val_i);
      OP_BLTU: take = rs1_val_i < rs2_val_i;
      OP_BGE:  take = !($signed(rs1_val_i) < $signed(rs2_val_i));
      OP_BGEU: take = rs1_val_i >= rs2_val_i;
      default: take = 1'b0;
    endcase
  end

  // instruction decode and result assembly
  always_comb begin
    r         = '0;
    r.next_pc = pc_i + 32'd4;
    r.ld_kind = LD_W;
    r.status  = ST_OK;
    if (halted_i) begin
      r.status  = ST_HALT;
      r.next_pc = pc_i;
    end else begin
      unique case (item_i.opcode) inside
        [OP_ADD:OP_SLTU]: begin
          r.reg_wr  = 1'b1;
          r.reg_val = alu_val;
        end
        [OP_ADDI:OP_SLTIU]: begin
          if (item_i.opcode inside {[OP_SLLI:OP_SRAI]}) begin
            if (!shamt_ok) begin
              r.status = ST_SHIFT;
            end else begin
              r.reg_wr  = 1'b1;
              r.reg_val = alu_val;
            end
          end else if (!imm12_ok) begin
            r.status = ST_IMM;
          end else begin
            r.reg_wr  = 1'b1;
            r.reg_val = alu_val;
          end
        end
        [OP_LW:OP_SB]: begin
          if (!imm12_ok) begin
            r.status = ST_IMM;
          end else begin
            r.mem_addr = maddr;
            case (item_i.opcode)
              OP_LW:  begin r.reg_wr = 1'b1; r.is_load = 1'b1; r.ld_kind = LD_W;  end
              OP_LH:  begin r.reg_wr = 1'b1; r.is_load = 1'b1; r.ld_kind = LD_H;  end
              OP_LB:  begin r.reg_wr = 1'b1; r.is_load = 1'b1; r.ld_kind = LD_B;  end
              OP_LHU: begin r.reg_wr = 1'b1; r.is_load = 1'b1; r.ld_kind = LD_HU; end
              OP_LBU: begin r.reg_wr = 1'b1; r.is_load = 1'b1; r.ld_kind = LD_BU; end
              OP_SW:  begin r.mem_wr = 1'b1; r.mem_val = rs2_val_i; end
              OP_SH:  begin r.mem_wr = 1'b1; r.mem_val = {16'h0000, rs2_val_i[15:0]}; end
              default: begin r.mem_wr = 1'b1; r.mem_val = {24'h000000, rs2_val_i[7:0]}; end
            endcase
          end
        end
        [OP_BEQ:OP_BGEU]: begin
          if (take) begin
            r.next_pc = item_i.target_address;
          end
        end
        OP_JAL: begin
          r.reg_wr  = 1'b1;
          r.reg_val = pc_i + 32'd4;
          r.next_pc = item_i.target_address;
        end
        OP_JALR: begin
          r.reg_wr  = 1'b1;
          r.reg_val = pc_i + 32'd4;
          r.next_pc = {maddr[31:1], 1'b0};
        end
        OP_LUI: begin
          r.reg_wr  = 1'b1;
          r.reg_val = {item_i.immediate[19:0], 12'h000};
        end
        OP_AUIPC: begin
          if (item_i.dest_reg != 5'd0) begin
            if (!imm20_ok) begin
              r.status = ST_IMM;
            end else if (!auipc_in_win) begin
              r.status = ST_WINDOW;
            end else begin
              r.reg_wr  = 1'b1;
              r.reg_val = auipc_sum[31:0];
            end
          end
        end
        default: ;
      endcase
    end

    // a fault or a halt leaves state untouched
    if (r.status != ST_OK) begin
      r.next_pc  = pc_i;
      r.reg_wr   = 1'b0;
      r.mem_wr   = 1'b0;
      r.is_load  = 1'b0;
      r.mem_addr = '0;
      r.mem_val  = '0;
    end
    if (item_i.dest_reg == 5'd0) begin
      r.reg_wr = 1'b0;
    end
    if (!r.reg_wr) begin
      r.reg_val = '0;
    end
    r.reg_idx = r.reg_wr ? item_i.dest_reg : 5'd0;
    res_o = r;
  end

endmodule

`default_nettype wire

>>> design/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Executes decoded RV32I instructions against a register file and data memory.
// ----------------------------------------------------------------------------
// Usage:
// - in_ch carries one decoded instruction per transaction; out_ch returns one
//   result per instruction, in order.
// - Pipeline: register file read at accept, execute and data memory read in
//   the next cycle, load extract and register write-back at the edge that
//   loads the output register.
// - The next instruction is taken when the previous one writes back, its
//   operands bypassed from that write; the registered register file and
//   memory reads set this spacing.
// - A result waiting in the output register does not block the next accept;
//   when out_ch stalls longer, the pipe fills and in_ch.ready drops.
// - After reset the data memory is cleared, one word a cycle, with in_ch.ready
//   low until the sweep ends. APB writes are taken meanwhile.
// - A range fault halts the unit until reset; later results report halted.
// - APB registers: start_pc (0x0, also loads the pc), data window low (0x4)
//   and high (0x8). Write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_execute_unit #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rvex_in_if.sink     in_ch,
  rvex_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rvex_pkg::*;

  localparam int unsigned IdxW = $clog2(MEM_WORDS);

  logic            in_acc;
  logic            e_adv;
  logic            m_adv;
  logic            cfg_wr;
  logic            clr_busy;
  item_t           in_item;
  logic            e_valid_q;
  item_t           e_item_q;
  logic            m_valid_q;
  exe_res_t        m_res_q;
  logic [IdxW-1:0] m_idx_q;
  exe_res_t        e_res;
  logic [IdxW-1:0] e_idx;
  logic [31:0]     rs1_val;
  logic [31:0]     rs2_val;
  logic [31:0]     ld_word;
  logic [31:0]     m_reg_val;
  exe_res_t        m_res_wb;
  logic [31:0]     pc_q;
  logic            halted_q;
  logic [31:0]     start_pc_q;
  logic [31:0]     win_lo_q;
  logic [31:0]     win_hi_q;
  logic            out_valid_q;
  exe_res_t        out_res_q;

  // handshakes
  assign in_acc = in_ch.valid && in_ch.ready;
  assign m_adv  = m_valid_q && (!out_valid_q || out_ch.ready);
  assign e_adv  = e_valid_q && (!m_valid_q || m_adv);
  assign in_ch.ready = !e_valid_q && (!m_valid_q || m_adv) && !clr_busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_item.opcode         = in_ch.opcode;
  assign in_item.dest_reg       = in_ch.dest_reg;
  assign in_item.src1_reg       = in_ch.src1_reg;
  assign in_item.src2_reg       = in_ch.src2_reg;
  assign in_item.immediate      = in_ch.immediate;
  assign in_item.target_address = in_ch.target_address;

  // register file, write-back from the memory stage
  rvex_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc),
    .rd_addr1_i (in_ch.src1_reg),
    .rd_addr2_i (in_ch.src2_reg),
    .rd_data1_o (rs1_val),
    .rd_data2_o (rs2_val),
    .wr_en_i    (m_adv && m_res_q.reg_wr),
    .wr_addr_i  (m_res_q.reg_idx),
    .wr_data_i  (m_reg_val)
  );

  rvex_exec u_exec (
    .item_i    (e_item_q),
    .rs1_val_i (rs1_val),
    .rs2_val_i (rs2_val),
    .pc_i      (pc_q),
    .halted_i  (halted_q),
    .win_lo_i  (win_lo_q),
    .win_hi_i  (win_hi_q),
    .res_o     (e_res)
  );

  rvex_widx #(.MEM_WORDS(MEM_WORDS)) u_widx (
    .addr_i (e_res.mem_addr),
    .idx_o  (e_idx)
  );

  rvex_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (e_adv && e_res.is_load),
    .rd_idx_i  (e_idx),
    .rd_data_o (ld_word),
    .wr_en_i   (m_adv && m_res_q.mem_wr),
    .wr_idx_i  (m_idx_q),
    .wr_data_i (m_res_q.mem_val),
    .busy_o    (clr_busy)
  );

  assign m_reg_val = (m_res_q.reg_wr && m_res_q.is_load)
                   ? load_ext(m_res_q.ld_kind, ld_word) : m_res_q.reg_val;

  // memory stage result with the loaded value merged in
  always_comb begin
    m_res_wb         = m_res_q;
    m_res_wb.reg_val = m_reg_val;
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        e_valid_q <= 1'b1;
      end else if (e_adv) begin
        e_valid_q <= 1'b0;
      end
      if (e_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_adv) begin
        m_valid_q <= 1'b0;
      end
      if (m_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_item_q <= in_item;
    end
    if (e_adv) begin
      m_res_q <= e_res;
      m_idx_q <= e_idx;
    end
    if (m_adv) begin
      out_res_q <= m_res_wb;
    end
  end

  // architectural pc, halt flag and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      halted_q   <= 1'b0;
      start_pc_q <= '0;
      win_lo_q   <= WIN_LO_RESET;
      win_hi_q   <= WIN_HI_RESET;
    end else begin
      if (e_adv) begin
        pc_q <= e_res.next_pc;
        if (e_res.status != ST_OK && e_res.status != ST_HALT) begin
          halted_q <= 1'b1;
        end
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_START_PC: begin
            start_pc_q <= pwdata;
            pc_q       <= pwdata;
          end
          REG_WIN_LO: win_lo_q <= pwdata;
          REG_WIN_HI: win_hi_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // apb read
  always_comb begin
    unique case (paddr[3:2])
      REG_START_PC: prdata = start_pc_q;
      REG_WIN_LO:   prdata = win_lo_q;
      REG_WIN_HI:   prdata = win_hi_q;
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // result channel
  assign out_ch.valid       = out_valid_q;
  assign out_ch.pc_after    = out_res_q.next_pc;
  assign out_ch.reg_written = out_res_q.reg_wr;
  assign out_ch.reg_index   = out_res_q.reg_idx;
  assign out_ch.reg_value   = out_res_q.reg_val;
  assign out_ch.mem_written = out_res_q.mem_wr;
  assign out_ch.mem_address = out_res_q.mem_addr;
  assign out_ch.mem_value   = out_res_q.mem_val;
  assign out_ch.status      = out_res_q.status;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  // no instruction enters while memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ch.ready)
    else $error("accept during memory clear");

  // operand interlock: one instruction in execute at a time
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> !in_ch.ready)
    else $error("accept while execute stage busy");

  // a halted result changes no state
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.status == ST_HALT) |-> (!out_ch.reg_written && !out_ch.mem_written))
    else $error("halted result reports a write");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rv32i execute unit. An in-bench predictor keeps
// its own register file, data memory, pc and halt flag and works out the
// result of every accepted instruction. Results are compared field by field
// in order. Stimulus runs in phases under different data windows and start
// pcs. The single range fault that halts the unit is left to the very end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import rvex_pkg::*;

typedef struct packed {
  logic [31:0] pc_after;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_written;
  logic [31:0] mem_address;
  logic [31:0] mem_value;
  logic [2:0]  status;
} exec_result_t;

class exec_scoreboard;
  localparam int DEPTH = 1024;
  logic [31:0]  rf[32];
  logic [31:0]  dmem[DEPTH];
  logic [31:0]  pc, win_lo, win_hi;
  bit           halted;
  exec_result_t pending[$];
  int           errors;

  function new();
    foreach (rf[i]) rf[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc = '0;
    win_lo = WIN_LO_RESET;
    win_hi = WIN_HI_RESET;
    halted = 0;
    errors = 0;
  endfunction

  function void configure(logic [1:0] idx, logic [31:0] v);
    case (idx)
      REG_START_PC: pc = v;
      REG_WIN_LO:   win_lo = v;
      REG_WIN_HI:   win_hi = v;
      default: ;
    endcase
  endfunction

  // executes one instruction; state changes only when commit is set
  function exec_result_t execute(item_t it, bit commit);
    exec_result_t r;
    logic [31:0] a, b, immu, nxt, val, maddr, mval, w;
    logic [4:0]  sh;
    logic [2:0]  st;
    bit          wr, mw, take;
    longint      imm, sum;
    a = rf[it.src1_reg];
    b = rf[it.src2_reg];
    imm = longint'(it.immediate);
    immu = 32'(imm);
    nxt = pc + 32'd4;
    st = ST_OK;
    wr = 0; mw = 0; val = '0; maddr = '0; mval = '0;
    if (halted) begin
      st = ST_HALT;
    end else if (it.opcode <= OP_SLTU) begin
      sh = b[4:0];
      wr = 1;
      case (it.opcode)
        OP_ADD:  val = a + b;
        OP_SUB:  val = a - b;
        OP_AND:  val = a & b;
        OP_OR:   val = a | b;
        OP_XOR:  val = a ^ b;
        OP_SLL:  val = a << sh;
        OP_SRL:  val = a >> sh;
        OP_SRA:  val = $signed(a) >>> sh;
        OP_SLT:  val = {31'd0, $signed(a) < $signed(b)};
        default: val = {31'd0, a < b};
      endcase
    end else if (it.opcode <= OP_SLTIU) begin
      if (it.opcode inside {OP_SLLI, OP_SRLI, OP_SRAI}) begin
        if (imm < 0 || imm > 31) st = ST_SHIFT;
      end else if (imm < -2048 || imm > 2047) begin
        st = ST_IMM;
      end
      if (st == ST_OK) begin
        sh = immu[4:0];
        wr = 1;
        case (it.opcode)
          OP_ADDI: val = a + immu;
          OP_ANDI: val = a & immu;
          OP_ORI:  val = a | immu;
          OP_XORI: val = a ^ immu;
          OP_SLLI: val = a << sh;
          OP_SRLI: val = a >> sh;
          OP_SRAI: val = $signed(a) >>> sh;
          OP_SLTI: val = {31'd0, $signed(a) < $signed(immu)};
          default: val = {31'd0, a < immu};
        endcase
      end
    end else if (it.opcode <= OP_SB) begin
      if (imm < -2048 || imm > 2047) begin
        st = ST_IMM;
      end else begin
        maddr = a + immu;
        w = dmem[maddr % DEPTH];
        case (it.opcode)
          OP_LW:  begin wr = 1; val = w; end
          OP_LH:  begin wr = 1; val = {{16{w[15]}}, w[15:0]}; end
          OP_LB:  begin wr = 1; val = {{24{w[7]}}, w[7:0]}; end
          OP_LHU: begin wr = 1; val = {16'd0, w[15:0]}; end
          OP_LBU: begin wr = 1; val = {24'd0, w[7:0]}; end
          OP_SW:  begin mw = 1; mval = b; end
          OP_SH:  begin mw = 1; mval = {16'd0, b[15:0]}; end
          default: begin mw = 1; mval = {24'd0, b[7:0]}; end
        endcase
      end
    end else if (it.opcode <= OP_BGEU) begin
      case (it.opcode)
        OP_BEQ:  take = a == b;
        OP_BNE:  take = a != b;
        OP_BLT:  take = $signed(a) < $signed(b);
        OP_BLTU: take = a < b;
        OP_BGE:  take = !($signed(a) < $signed(b));
        default: take = a >= b;
      endcase
      if (take) nxt = it.target_address;
    end else if (it.opcode == OP_JAL) begin
      wr = 1; val = pc + 32'd4; nxt = it.target_address;
    end else if (it.opcode == OP_JALR) begin
      wr = 1; val = pc + 32'd4; nxt = (a + immu) & ~32'd1;
    end else if (it.opcode == OP_LUI) begin
      wr = 1; val = {immu[19:0], 12'd0};
    end else if (it.opcode == OP_AUIPC && it.dest_reg != 0) begin
      if (imm < -524288 || imm > 524287) begin
        st = ST_IMM;
      end else begin
        sum = longint'({32'd0, pc}) + imm * 4096;
        if (sum < longint'({32'd0, win_lo}) || sum > longint'({32'd0, win_hi})) begin
          st = ST_WINDOW;
        end else begin
          wr = 1; val = 32'(sum);
        end
      end
    end
    // faults and halt freeze everything
    if (st != ST_OK) begin
      nxt = pc; wr = 0; mw = 0; val = '0; maddr = '0; mval = '0;
    end
    if (it.dest_reg == 0) wr = 0;
    if (!wr) val = '0;
    if (commit) begin
      if (st != ST_OK) halted = 1;
      if (wr) rf[it.dest_reg] = val;
      if (mw) dmem[maddr % DEPTH] = mval;
      pc = nxt;
    end
    r.pc_after    = nxt;
    r.reg_written = wr;
    r.reg_index   = wr ? it.dest_reg : 5'd0;
    r.reg_value   = val;
    r.mem_written = mw;
    r.mem_address = maddr;
    r.mem_value   = mval;
    r.status      = st;
    return r;
  endfunction

  function void note_input(item_t it);
    pending.push_back(execute(it, 1));
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(exec_result_t got);
    exec_result_t exp;
    if (pending.size() == 0) begin
      report("result with no instruction outstanding");
      return;
    end
    exp = pending.pop_front();
    if (got.pc_after != exp.pc_after)
      report($sformatf("pc_after %h exp %h", got.pc_after, exp.pc_after));
    if (got.reg_written != exp.reg_written)
      report($sformatf("reg_written %b exp %b", got.reg_written, exp.reg_written));
    if (got.reg_index != exp.reg_index)
      report($sformatf("reg_index %0d exp %0d", got.reg_index, exp.reg_index));
    if (got.reg_value != exp.reg_value)
      report($sformatf("reg_value %h exp %h", got.reg_value, exp.reg_value));
    if (got.mem_written != exp.mem_written)
      report($sformatf("mem_written %b exp %b", got.mem_written, exp.mem_written));
    if (got.mem_address != exp.mem_address)
      report($sformatf("mem_address %h exp %h", got.mem_address, exp.mem_address));
    if (got.mem_value != exp.mem_value)
      report($sformatf("mem_value %h exp %h", got.mem_value, exp.mem_value));
    if (got.status != exp.status)
      report($sformatf("status %0d exp %0d", got.status, exp.status));
  endtask
endclass

module tb_top;
  localparam int LIMIT = 300000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  bit          no_idle, hold_req, hold_done;
  int          hold_left, cyc;

  rvex_in_if  in_ch ();
  rvex_out_if out_ch ();

  exec_scoreboard sb = new();

  rv32i_execute_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each transaction, random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.pc_after, out_ch.reg_written, out_ch.reg_index,
                          out_ch.reg_value, out_ch.mem_written, out_ch.mem_address,
                          out_ch.mem_value, out_ch.status});
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  task apb_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.configure(idx, v);
  endtask

  // one instruction transaction; the prediction follows the accept
  task send(item_t it);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= it.opcode;
    in_ch.dest_reg       <= it.dest_reg;
    in_ch.src1_reg       <= it.src1_reg;
    in_ch.src2_reg       <= it.src2_reg;
    in_ch.immediate      <= it.immediate;
    in_ch.target_address <= it.target_address;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  // keeps the unit running: a would-be fault turns into a plain add
  task send_clean(item_t it);
    if (sb.execute(it, 0).status != ST_OK) it.opcode = OP_ADD;
    send(it);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function item_t mk(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                     int imm, logic [31:0] tgt);
    return '{op, rd, rs1, rs2, 21'(imm), tgt};
  endfunction

  function item_t rand_item();
    item_t it;
    int    pick;
    it.opcode         = 6'($urandom_range(36));
    it.dest_reg       = 5'($urandom);
    it.src1_reg       = 5'($urandom);
    it.src2_reg       = ($urandom_range(9) == 0) ? it.src1_reg : 5'($urandom);
    it.target_address = $urandom;
    it.immediate      = 21'($urandom);
    pick = $urandom_range(99);
    if (pick < 3)
      it.opcode = 6'($urandom_range(63, 37));
    else if (it.opcode inside {OP_SLLI, OP_SRLI, OP_SRAI})
      it.immediate = 21'($urandom_range(31));
    else if (it.opcode >= OP_ADDI && it.opcode <= OP_SB)
      it.immediate = 21'($signed($urandom_range(4095)) - 2048);
    else if (it.opcode == OP_AUIPC && pick < 60)
      it.immediate = 21'($signed($urandom_range(63)) - 32);
    return it;
  endfunction

  task run_random(int n);
    repeat (n) send_clean(rand_item());
  endtask

  initial begin
    item_t last;
    int    kind;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.dest_reg = '0;
    in_ch.src1_reg = '0; in_ch.src2_reg = '0; in_ch.immediate = '0;
    in_ch.target_address = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase one: wide data window, pc near the top to see wrap
    apb_write(REG_WIN_LO, 32'h0000_0000);
    apb_write(REG_WIN_HI, 32'hFFFF_FFFF);
    apb_write(REG_START_PC, 32'hFFFF_FFF8);
    send_clean(mk(OP_ADDI, 1, 0, 0, 2047, 0));
    send_clean(mk(OP_ADDI, 2, 0, 0, -2048, 0));
    send_clean(mk(OP_LUI, 3, 0, 0, -1, 0));
    send_clean(mk(OP_ADD, 4, 1, 2, 0, 0));
    send_clean(mk(OP_SUB, 5, 2, 1, 0, 0));
    send_clean(mk(OP_SRA, 6, 3, 2, 0, 0));
    send_clean(mk(OP_SRL, 7, 3, 1, 0, 0));
    send_clean(mk(OP_SLT, 8, 3, 1, 0, 0));
    send_clean(mk(OP_SLTU, 9, 3, 1, 0, 0));
    send_clean(mk(OP_SLLI, 10, 1, 0, 31, 0));
    send_clean(mk(OP_SRAI, 11, 10, 0, 31, 0));
    send_clean(mk(OP_SLTIU, 12, 1, 0, -1, 0));
    send_clean(mk(OP_SW, 0, 0, 3, 2047, 0));
    send_clean(mk(OP_SH, 0, 1, 2, 1024, 0));
    send_clean(mk(OP_LB, 13, 0, 0, 2047, 0));
    send_clean(mk(OP_LHU, 14, 1, 0, 1024, 0));
    send_clean(mk(OP_LH, 0, 1, 0, 1024, 0));
    send_clean(mk(OP_BGE, 0, 3, 1, 0, 32'hFFFF_FFFC));
    send_clean(mk(OP_BLTU, 0, 1, 3, 0, 32'h0000_0100));
    send_clean(mk(OP_JAL, 31, 0, 0, 0, 32'h0000_0400));
    send_clean(mk(OP_JALR, 15, 1, 0, -1, 0));
    send_clean(mk(OP_AUIPC, 0, 0, 0, -1048576, 0));
    send_clean(mk(OP_AUIPC, 16, 0, 0, 524287, 0));
    send_clean(mk(OP_LUI, 0, 0, 0, 1048575, 0));
    send_clean(mk(6'd63, 0, 0, 0, 0, 0));
    run_random(380);
    drain();

    // phase two: upper half window, no idling on either side at first, then random idling
    apb_write(REG_START_PC, 32'hFFFF_FFFC);
    apb_write(REG_WIN_LO, 32'h8000_0000);
    apb_write(REG_WIN_HI, 32'hFFFF_FFFF);
    no_idle = 1;
    run_random(200);
    no_idle = 0;
    run_random(150);
    drain();

    // phase three: low window; receiver holds off while instructions pile up
    apb_write(REG_START_PC, 32'h0000_1000);
    apb_write(REG_WIN_LO, 32'h0000_0000);
    apb_write(REG_WIN_HI, 32'h7FFF_FFFF);
    hold_req = 1;
    run_random(400);
    drain();

    // closing fault, then a few instructions seen while halted
    apb_write(REG_WIN_LO, 32'hFFFF_FFFF);
    apb_write(REG_WIN_HI, 32'h0000_0000);
    kind = $urandom_range(2);
    if (kind == 0) last = mk(OP_ADDI, 1, 1, 0, 2048, 0);
    else if (kind == 1) last = mk(OP_SRLI, 1, 1, 0, 32, 0);
    else last = mk(OP_AUIPC, 1, 0, 0, 1, 0);
    send(last);
    repeat (3) send(rand_item());
    drain();

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
